@@ hdl/dcsr_pkg.sv @@
// Shared types and constants for the dense-to-CSR encoder.
// Used by every module of the block but dcsr_desc_fifo; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dcsr_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_DIM    = 4096;
    localparam int DEF_VALUE_BITS = 16;

    // Fixed field widths.
    localparam int DIM_BITS       = 13;
    localparam int THR_BITS       = 15;
    localparam int COUNT_BITS     = 25;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 15;

    // Depth of the descriptor queue between the front and back parts.
    localparam int DESC_DEPTH = 4;

    // Reset values of the configuration registers.
    localparam logic [DIM_BITS-1:0] COLUMN_COUNT_RESET   = DIM_BITS'(64);
    localparam logic [DIM_BITS-1:0] ROW_COUNT_RESET      = DIM_BITS'(64);
    localparam logic [THR_BITS-1:0] ZERO_THRESHOLD_RESET = '0;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_COLUMN_COUNT   = 2'd0,
        REG_ROW_COUNT      = 2'd1,
        REG_ZERO_THRESHOLD = 2'd2
    } cfg_index_t;

    // Result kind codes.
    typedef enum logic {
        KIND_ENTRY  = 1'b0,
        KIND_OFFSET = 1'b1
    } result_kind_t;

    // Configuration in force.
    typedef struct packed {
        logic [DIM_BITS-1:0] column_count;
        logic [DIM_BITS-1:0] row_count;
        logic [THR_BITS-1:0] zero_threshold;
    } cfg_t;

    // Which results one element causes.
    typedef struct packed {
        logic has_open;
        logic has_entry;
        logic has_offset;
        logic mat_end;
    } desc_flags_t;

    localparam int FLAG_BITS = $bits(desc_flags_t);

endpackage

`default_nettype wire

@@ hdl/dcsr_front.sv @@
// Front part of the dense-to-CSR encoder: configuration registers, element
// classification and the row, column and nonzero counters. Depends on dcsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcsr_front #(
    parameter int MAX_DIM    = dcsr_pkg::DEF_MAX_DIM,
    parameter int VALUE_BITS = dcsr_pkg::DEF_VALUE_BITS,
    parameter int POS_BITS   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // Configuration writes
    input  wire                                   cfg_write,
    input  wire [dcsr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire [dcsr_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // Element transfer
    input  wire                                   in_accept,
    input  wire signed [VALUE_BITS-1:0]           element_value,
    // Descriptor towards the queue
    output logic                                  desc_push,
    output dcsr_pkg::desc_flags_t                 desc_flags,
    output logic [VALUE_BITS-1:0]                 desc_value,
    output logic [POS_BITS-1:0]                   desc_column,
    output logic [dcsr_pkg::COUNT_BITS-1:0]       desc_offset
);

    localparam int CMP_BITS = (POS_BITS + 1 > dcsr_pkg::DIM_BITS) ? POS_BITS + 1
                                                                 : dcsr_pkg::DIM_BITS;
    localparam int MAG_BITS = (VALUE_BITS > dcsr_pkg::THR_BITS) ? VALUE_BITS
                                                               : dcsr_pkg::THR_BITS;
    localparam logic [CMP_BITS-1:0] MAX_EXT = CMP_BITS'(MAX_DIM);
    localparam logic [dcsr_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    dcsr_pkg::cfg_t                     cfg_reg;
    dcsr_pkg::cfg_t                     cfg_next;
    logic [POS_BITS-1:0]                col_pos_reg;
    logic [POS_BITS-1:0]                col_pos_next;
    logic [POS_BITS-1:0]                row_pos_reg;
    logic [POS_BITS-1:0]                row_pos_next;
    logic [dcsr_pkg::COUNT_BITS-1:0]    count_reg;
    logic [dcsr_pkg::COUNT_BITS-1:0]    count_next;

    logic [CMP_BITS-1:0]                cols_eff;
    logic [CMP_BITS-1:0]                rows_eff;
    logic [VALUE_BITS-1:0]              magnitude;
    logic                               nonzero;
    logic                               row_end;
    logic                               mat_end;
    logic                               first;
    logic [dcsr_pkg::COUNT_BITS-1:0]    count_inc;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                dcsr_pkg::REG_COLUMN_COUNT:
                    cfg_next.column_count = cfg_data[dcsr_pkg::DIM_BITS-1:0];
                dcsr_pkg::REG_ROW_COUNT:
                    cfg_next.row_count = cfg_data[dcsr_pkg::DIM_BITS-1:0];
                dcsr_pkg::REG_ZERO_THRESHOLD:
                    cfg_next.zero_threshold = cfg_data[dcsr_pkg::THR_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Dimensions in force: zero acts as one, and anything above the maximum is clamped.
    always_comb
    begin
        if (cfg_reg.column_count == '0)
            cols_eff = CMP_BITS'(1);
        else if (CMP_BITS'(cfg_reg.column_count) > MAX_EXT)
            cols_eff = MAX_EXT;
        else
            cols_eff = CMP_BITS'(cfg_reg.column_count);

        if (cfg_reg.row_count == '0)
            rows_eff = CMP_BITS'(1);
        else if (CMP_BITS'(cfg_reg.row_count) > MAX_EXT)
            rows_eff = MAX_EXT;
        else
            rows_eff = CMP_BITS'(cfg_reg.row_count);
    end

    // Classification of the incoming element.
    always_comb
    begin
        magnitude = element_value[VALUE_BITS-1] ? (~element_value + VALUE_BITS'(1))
                                                : element_value;
        nonzero   = MAG_BITS'(magnitude) > MAG_BITS'(cfg_reg.zero_threshold);
        row_end   = (CMP_BITS'(col_pos_reg) + CMP_BITS'(1)) >= cols_eff;
        mat_end   = row_end && ((CMP_BITS'(row_pos_reg) + CMP_BITS'(1)) >= rows_eff);
        first     = (col_pos_reg == '0) && (row_pos_reg == '0);
        count_inc = (nonzero && (count_reg != COUNT_MAX)) ? count_reg + 1'b1 : count_reg;
    end

    // Descriptor for the back part; an element that causes no result is not queued.
    always_comb
    begin
        desc_flags.has_open   = first;
        desc_flags.has_entry  = nonzero;
        desc_flags.has_offset = row_end;
        desc_flags.mat_end    = mat_end;
        desc_value            = element_value;
        desc_column           = col_pos_reg;
        desc_offset           = count_inc;
        desc_push             = in_accept && (first || nonzero || row_end);
    end

    // Counter updates on each element transfer.
    always_comb
    begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        count_next   = count_reg;
        if (in_accept)
        begin
            count_next = count_inc;
            if (row_end)
            begin
                col_pos_next = '0;
                if (mat_end)
                begin
                    row_pos_next = '0;
                    count_next   = '0;
                end
                else
                begin
                    row_pos_next = row_pos_reg + 1'b1;
                end
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_count   <= dcsr_pkg::COLUMN_COUNT_RESET;
            cfg_reg.row_count      <= dcsr_pkg::ROW_COUNT_RESET;
            cfg_reg.zero_threshold <= dcsr_pkg::ZERO_THRESHOLD_RESET;
            col_pos_reg            <= '0;
            row_pos_reg            <= '0;
            count_reg              <= '0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/dcsr_desc_fifo.sv @@
// Short descriptor queue between the front and back parts of the encoder.
// Generic width and depth; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module dcsr_desc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              wr_en,
    input  wire [WIDTH-1:0]  wr_data,
    output logic             full,
    input  wire              rd_en,
    output logic             not_empty,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] fill_reg;
    logic [CNT_BITS-1:0] fill_next;
    logic                do_wr;
    logic                do_rd;

    // Pointer and fill level updates.
    always_comb
    begin
        full        = fill_reg == CNT_BITS'(DEPTH);
        not_empty   = fill_reg != '0;
        do_wr       = wr_en && !full;
        do_rd       = rd_en && not_empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            fill_next = fill_reg + 1'b1;
        else if (do_rd && !do_wr)
            fill_next = fill_reg - 1'b1;
        rd_data = slot_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

@@ hdl/dcsr_back.sv @@
// Back part of the dense-to-CSR encoder: expands each descriptor into its
// results, one a cycle into a free result register. Depends on dcsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcsr_back #(
    parameter int VALUE_BITS = dcsr_pkg::DEF_VALUE_BITS,
    parameter int POS_BITS   = 12
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // Descriptor at the head of the queue
    input  wire                                   head_valid,
    input  dcsr_pkg::desc_flags_t                 head_flags,
    input  wire [VALUE_BITS-1:0]                  head_value,
    input  wire [POS_BITS-1:0]                    head_column,
    input  wire [dcsr_pkg::COUNT_BITS-1:0]        head_offset,
    output logic                                  head_pop,
    // Result side
    input  wire                                   pop,
    output logic                                  empty,
    output logic                                  result_kind,
    output logic signed [VALUE_BITS-1:0]          entry_value,
    output logic [POS_BITS-1:0]                   column_index,
    output logic [dcsr_pkg::COUNT_BITS-1:0]       row_offset,
    output logic                                  last_of_run,
    output logic                                  matrix_done
);

    // Bit order of the progress mask: opening offset, entry, closing offset.
    logic [2:0]                         done_reg;
    logic [2:0]                         done_next;
    logic [2:0]                         remaining;
    logic [2:0]                         pick;
    logic                               emit;
    logic                               is_last;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    dcsr_pkg::result_kind_t             kind_reg;
    dcsr_pkg::result_kind_t             kind_next;
    logic [VALUE_BITS-1:0]              value_reg;
    logic [VALUE_BITS-1:0]              value_next;
    logic [POS_BITS-1:0]                column_reg;
    logic [POS_BITS-1:0]                column_next;
    logic [dcsr_pkg::COUNT_BITS-1:0]    offset_reg;
    logic [dcsr_pkg::COUNT_BITS-1:0]    offset_next;
    logic                               last_reg;
    logic                               last_next;
    logic                               done_flag_reg;
    logic                               done_flag_next;

    // Pick the next result of the head descriptor, in model order.
    always_comb
    begin
        remaining = {head_flags.has_offset, head_flags.has_entry, head_flags.has_open}
                    & ~done_reg;
        priority if (remaining[0])
            pick = 3'b001;
        else if (remaining[1])
            pick = 3'b010;
        else
            pick = 3'b100;
        is_last  = (remaining & ~pick) == '0;
        emit     = head_valid && (!out_valid_reg || pop);
        head_pop = emit && is_last;
    end

    // Progress through the head descriptor and the result register load.
    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg && !pop;
        kind_next      = kind_reg;
        value_next     = value_reg;
        column_next    = column_reg;
        offset_next    = offset_reg;
        last_next      = last_reg;
        done_flag_next = done_flag_reg;
        if (emit)
        begin
            done_next      = is_last ? '0 : (done_reg | pick);
            out_valid_next = 1'b1;
            last_next      = is_last;
            priority if (pick[0])
            begin
                kind_next      = dcsr_pkg::KIND_OFFSET;
                value_next     = '0;
                column_next    = '0;
                offset_next    = '0;
                done_flag_next = 1'b0;
            end
            else if (pick[1])
            begin
                kind_next      = dcsr_pkg::KIND_ENTRY;
                value_next     = head_value;
                column_next    = head_column;
                offset_next    = '0;
                done_flag_next = 1'b0;
            end
            else
            begin
                kind_next      = dcsr_pkg::KIND_OFFSET;
                value_next     = '0;
                column_next    = '0;
                offset_next    = head_offset;
                done_flag_next = head_flags.mat_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload holds no reset.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        value_reg     <= value_next;
        column_reg    <= column_next;
        offset_reg    <= offset_next;
        last_reg      <= last_next;
        done_flag_reg <= done_flag_next;
    end

    assign empty        = !out_valid_reg;
    assign result_kind  = kind_reg;
    assign entry_value  = value_reg;
    assign column_index = column_reg;
    assign row_offset   = offset_reg;
    assign last_of_run  = last_reg;
    assign matrix_done  = done_flag_reg;

endmodule

`default_nettype wire

@@ hdl/dense_to_csr_encoder.sv @@
// Top level of the dense-to-CSR encoder: front part, descriptor queue and back part.
// Depends on dcsr_pkg, dcsr_front, dcsr_desc_fifo and dcsr_back.
`timescale 1ns / 1ps
`default_nettype none

// Dense elements enter in row-major order, one per cycle at most, through a
// queue-style push/full port; results leave through a pop/empty port in the
// order opening row offset, nonzero entry, closing row offset. The front part
// classifies each element and updates the counters in the cycle it is taken,
// so the input sustains one element per clock unless the queue is full. The
// back part writes one result a clock into the result register when it is
// empty or being popped; an element with no result costs it nothing, and a
// four-entry descriptor queue between the two absorbs bursts of row ends.
// When the queue and the back part are idle, the first result of an element
// is registered in a queue slot and then in the result register before it
// is on the ports. Configuration writes are always taken (cfg_ready is
// high) and must be made while the block is idle.
module dense_to_csr_encoder #(
    parameter int MAX_DIM    = dcsr_pkg::DEF_MAX_DIM,
    parameter int VALUE_BITS = dcsr_pkg::DEF_VALUE_BITS,
    parameter int POS_BITS   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // Configuration channel
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [dcsr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire [dcsr_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    // Element input
    input  wire                                   push,
    output logic                                  full,
    input  wire signed [VALUE_BITS-1:0]           element_value,
    // Result output
    input  wire                                   pop,
    output logic                                  empty,
    output logic                                  result_kind,
    output logic signed [VALUE_BITS-1:0]          entry_value,
    output logic [POS_BITS-1:0]                   column_index,
    output logic [dcsr_pkg::COUNT_BITS-1:0]       row_offset,
    output logic                                  last_of_run,
    output logic                                  matrix_done
);

    localparam int DESC_BITS = dcsr_pkg::FLAG_BITS + VALUE_BITS + POS_BITS
                               + dcsr_pkg::COUNT_BITS;

    logic                               in_accept;
    logic                               desc_push;
    dcsr_pkg::desc_flags_t              desc_flags;
    logic [VALUE_BITS-1:0]              desc_value;
    logic [POS_BITS-1:0]                desc_column;
    logic [dcsr_pkg::COUNT_BITS-1:0]    desc_offset;
    logic [DESC_BITS-1:0]               wr_word;
    logic [DESC_BITS-1:0]               rd_word;
    logic                               head_valid;
    logic                               head_pop;
    dcsr_pkg::desc_flags_t              head_flags;
    logic [VALUE_BITS-1:0]              head_value;
    logic [POS_BITS-1:0]                head_column;
    logic [dcsr_pkg::COUNT_BITS-1:0]    head_offset;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign in_accept = push && !full;

    dcsr_front #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS),
        .POS_BITS   (POS_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_accept     (in_accept),
        .element_value (element_value),
        .desc_push     (desc_push),
        .desc_flags    (desc_flags),
        .desc_value    (desc_value),
        .desc_column   (desc_column),
        .desc_offset   (desc_offset)
    );

    // Descriptor packing across the queue.
    assign wr_word = {desc_flags, desc_value, desc_column, desc_offset};
    assign {head_flags, head_value, head_column, head_offset} = rd_word;

    dcsr_desc_fifo #(
        .WIDTH (DESC_BITS),
        .DEPTH (dcsr_pkg::DESC_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (desc_push),
        .wr_data   (wr_word),
        .full      (full),
        .rd_en     (head_pop),
        .not_empty (head_valid),
        .rd_data   (rd_word)
    );

    dcsr_back #(
        .VALUE_BITS (VALUE_BITS),
        .POS_BITS   (POS_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_flags   (head_flags),
        .head_value   (head_value),
        .head_column  (head_column),
        .head_offset  (head_offset),
        .head_pop     (head_pop),
        .pop          (pop),
        .empty        (empty),
        .result_kind  (result_kind),
        .entry_value  (entry_value),
        .column_index (column_index),
        .row_offset   (row_offset),
        .last_of_run  (last_of_run),
        .matrix_done  (matrix_done)
    );

endmodule

`default_nettype wire
